>>> rtl/core/cstp_pkg.sv
// Shared types and constants of the call-stack exclusive-time profiler.
package cstp_pkg;

  // Field widths of the request and result items
  localparam int OP_W     = 2;
  localparam int TS_W     = 64;
  localparam int FN_W     = 12;
  localparam int DEPTH_W  = 7;
  localparam int STATUS_W = 2;

  // Storage sizes
  localparam int MAX_FUNCTIONS = 4096;
  localparam int STACK_DEPTH   = 64;
  localparam int TOT_AW        = $clog2(MAX_FUNCTIONS);
  localparam int STK_AW        = $clog2(STACK_DEPTH);
  localparam int SP_W          = $clog2(STACK_DEPTH + 1);

  // Queue between the front and the back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Operation codes on the request channel
  localparam logic [OP_W-1:0] OPC_CALL   = 2'd0;
  localparam logic [OP_W-1:0] OPC_RETURN = 2'd1;

  // Status codes on the result channel
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

  typedef enum logic [1:0] {
    KIND_CALL,
    KIND_RETURN,
    KIND_READ
  } cstp_kind_t;

  // Classified request as it travels through the queue
  typedef struct packed {
    cstp_kind_t        kind;
    logic [TS_W-1:0]   elapsed;
    logic [FN_W-1:0]   func;
  } cstp_entry_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_ISSUE,
    BK_FINISH
  } cstp_back_state_t;

endpackage

>>> rtl/core/cstp_in_if.sv
// Request channel: event operation, timestamp and function index.
interface cstp_in_if;
  logic                        valid;
  logic                        ready;
  logic [cstp_pkg::OP_W-1:0]   operation;
  logic [cstp_pkg::TS_W-1:0]   timestamp;
  logic [cstp_pkg::FN_W-1:0]   function_index;

  modport source (output valid, output operation, output timestamp,
                  output function_index, input ready);
  modport sink   (input valid, input operation, input timestamp,
                  input function_index, output ready);
endinterface

>>> rtl/core/cstp_out_if.sv
// Result channel: charged function, total time, stack depth and status.
interface cstp_out_if;
  logic                            valid;
  logic                            ready;
  logic [cstp_pkg::FN_W-1:0]       charged_function;
  logic                            outside_any_function;
  logic [cstp_pkg::TS_W-1:0]       total_time;
  logic [cstp_pkg::DEPTH_W-1:0]    stack_depth;
  logic [cstp_pkg::STATUS_W-1:0]   status;

  modport source (output valid, output charged_function, output outside_any_function,
                  output total_time, output stack_depth, output status, input ready);
  modport sink   (input valid, input charged_function, input outside_any_function,
                  input total_time, input stack_depth, input status, output ready);
endinterface

>>> rtl/core/cstp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cstp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and read the array
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/cstp_front.sv
// Front end: accept requests, classify them and compute elapsed time.
module cstp_front (
  input  logic                  clk,
  input  logic                  rst_n,
  cstp_in_if.sink               in_if,
  input  logic                  clearing,
  output logic                  push_valid,
  output cstp_pkg::cstp_entry_t push_entry,
  input  logic                  push_ready
);
  import cstp_pkg::*;

  logic [TS_W-1:0] last_ts_r;
  logic [TS_W-1:0] last_ts_nxt;
  logic            accept;
  cstp_kind_t      kind;

  // Hold requests while the totals table is being cleared
  assign in_if.ready = push_ready && !clearing;
  assign push_valid  = in_if.valid && !clearing;
  assign accept      = in_if.valid && in_if.ready;

  // Classify the operation; unknown codes act as reads
  always_comb begin
    case (in_if.operation)
      OPC_CALL:   kind = KIND_CALL;
      OPC_RETURN: kind = KIND_RETURN;
      default:    kind = KIND_READ;
    endcase
  end

  // Build the queue entry with the modular elapsed time
  always_comb begin
    push_entry.kind    = kind;
    push_entry.elapsed = in_if.timestamp - last_ts_r;
    push_entry.func    = in_if.function_index;
  end

  // Advance the last timestamp on calls and returns
  always_comb begin
    last_ts_nxt = last_ts_r;
    if (accept && kind != KIND_READ) begin
      last_ts_nxt = in_if.timestamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_ts_r <= '0;
    end else begin
      last_ts_r <= last_ts_nxt;
    end
  end

endmodule

>>> rtl/core/cstp_queue.sv
// Short request queue between the front end and the back end.
module cstp_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  input  cstp_pkg::cstp_entry_t push_entry,
  output logic                  push_ready,
  output logic                  pop_valid,
  output cstp_pkg::cstp_entry_t pop_entry,
  input  logic                  pop_ready
);
  import cstp_pkg::*;

  cstp_entry_t        slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_ready = count_r != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_entry  = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

>>> rtl/core/cstp_back.sv
// Back end: call stack, totals read-modify-write and result register.
module cstp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  pop_valid,
  input  cstp_pkg::cstp_entry_t pop_entry,
  output logic                  pop_ready,
  output logic                  clearing,
  cstp_out_if.source            out_if
);
  import cstp_pkg::*;

  cstp_back_state_t    state_r, state_nxt;
  cstp_entry_t         cur_r, cur_nxt;
  logic [SP_W-1:0]     sp_r, sp_nxt;
  logic [FN_W-1:0]     top_r, top_nxt;
  logic [TOT_AW-1:0]   clr_cnt_r, clr_cnt_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [FN_W-1:0]     out_func_r, out_func_nxt;
  logic                out_outside_r, out_outside_nxt;
  logic [TS_W-1:0]     out_total_r, out_total_nxt;
  logic [DEPTH_W-1:0]  out_depth_r, out_depth_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic                tot_we;
  logic [TOT_AW-1:0]   tot_waddr, tot_raddr;
  logic [TS_W-1:0]     tot_wdata, tot_rdata;
  logic                stk_we;
  logic [STK_AW-1:0]   stk_waddr, stk_raddr;
  logic [FN_W-1:0]     stk_rdata;

  logic                top_ok;
  logic                idx_ok;
  logic [TS_W:0]       sum;
  logic [TS_W-1:0]     sat_total;

  cstp_ram #(.WIDTH(TS_W), .DEPTH(MAX_FUNCTIONS)) u_totals (
    .clk   (clk),
    .we    (tot_we),
    .waddr (tot_waddr),
    .wdata (tot_wdata),
    .raddr (tot_raddr),
    .rdata (tot_rdata)
  );

  cstp_ram #(.WIDTH(FN_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (cur_r.func),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign clearing = state_r == BK_CLEAR;

  // Saturating add of the elapsed time to the current function's total
  assign top_ok    = 32'(top_r) < MAX_FUNCTIONS;
  assign idx_ok    = 32'(cur_r.func) < MAX_FUNCTIONS;
  assign sum       = {1'b0, tot_rdata} + {1'b0, cur_r.elapsed};
  assign sat_total = sum[TS_W] ? '1 : sum[TS_W-1:0];

  // Next state, memory accesses and result
  always_comb begin
    state_nxt       = state_r;
    cur_nxt         = cur_r;
    sp_nxt          = sp_r;
    top_nxt         = top_r;
    clr_cnt_nxt     = clr_cnt_r;
    out_valid_nxt   = out_valid_r && !out_if.ready;
    out_func_nxt    = out_func_r;
    out_outside_nxt = out_outside_r;
    out_total_nxt   = out_total_r;
    out_depth_nxt   = out_depth_r;
    out_status_nxt  = out_status_r;
    pop_ready       = 1'b0;
    tot_we          = 1'b0;
    tot_waddr       = TOT_AW'(top_r);
    tot_wdata       = sat_total;
    tot_raddr       = TOT_AW'(top_r);
    stk_we          = 1'b0;
    stk_waddr       = STK_AW'(sp_r);
    stk_raddr       = STK_AW'(sp_r - SP_W'(2));

    case (state_r)
      // Sweep zeros through the totals table
      BK_CLEAR: begin
        tot_we      = 1'b1;
        tot_waddr   = clr_cnt_r;
        tot_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == TOT_AW'(MAX_FUNCTIONS - 1)) begin
          state_nxt = BK_ISSUE;
        end
      end

      // Take a request once the result register will be free; issue reads
      BK_ISSUE: begin
        pop_ready = !out_valid_r || out_if.ready;
        if (pop_entry.kind == KIND_READ) begin
          tot_raddr = TOT_AW'(pop_entry.func);
        end
        if (pop_valid && pop_ready) begin
          cur_nxt   = pop_entry;
          state_nxt = BK_FINISH;
        end
      end

      // Charge or query, update the stack, load the result
      BK_FINISH: begin
        out_valid_nxt   = 1'b1;
        out_status_nxt  = STATUS_OK;
        out_outside_nxt = 1'b0;
        if (cur_r.kind == KIND_READ) begin
          out_func_nxt  = cur_r.func;
          out_total_nxt = idx_ok ? tot_rdata : '0;
        end else begin
          if (sp_r == '0) begin
            out_func_nxt    = '0;
            out_outside_nxt = 1'b1;
            out_total_nxt   = '0;
          end else begin
            out_func_nxt  = top_r;
            out_total_nxt = top_ok ? sat_total : '0;
            tot_we        = top_ok;
          end
          if (cur_r.kind == KIND_CALL) begin
            if (sp_r == SP_W'(STACK_DEPTH)) begin
              out_status_nxt = STATUS_OVERFLOW;
            end else begin
              stk_we  = 1'b1;
              top_nxt = cur_r.func;
              sp_nxt  = sp_r + 1'b1;
            end
          end else begin
            if (sp_r == '0) begin
              out_status_nxt = STATUS_UNDERFLOW;
            end else begin
              top_nxt = stk_rdata;
              sp_nxt  = sp_r - 1'b1;
            end
          end
        end
        out_depth_nxt = DEPTH_W'(sp_nxt);
        state_nxt     = BK_ISSUE;
      end

      default: begin
        state_nxt = BK_CLEAR;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      sp_r        <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r         <= cur_nxt;
    top_r         <= top_nxt;
    out_func_r    <= out_func_nxt;
    out_outside_r <= out_outside_nxt;
    out_total_r   <= out_total_nxt;
    out_depth_r   <= out_depth_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign out_if.valid                = out_valid_r;
  assign out_if.charged_function     = out_func_r;
  assign out_if.outside_any_function = out_outside_r;
  assign out_if.total_time           = out_total_r;
  assign out_if.stack_depth          = out_depth_r;
  assign out_if.status               = out_status_r;

`ifndef ASSERT_OFF
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_finish_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_FINISH |-> !out_valid_r)
    else $error("result register busy when a result is loaded");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_CLEAR |-> !out_valid_r && !pop_ready)
    else $error("activity during totals clearing");

  a_sp_only_finish: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != BK_FINISH |=> sp_r == $past(sp_r))
    else $error("stack pointer moved outside finish step");
`endif

endmodule

>>> rtl/core/call_stack_exclusive_time_profiler.sv
// Call-stack exclusive-time profiler top level.
//
// Requests arrive on in_if (valid/ready): operation call, return or read,
// a 64-bit timestamp and a 12-bit function index. Each request gives one
// result on out_if (valid/ready): charged function, outside flag, total
// time, stack depth after the event and status.
// Calls and returns charge the time since the previous call or return to
// the function on top of the stack (saturating), then push or pop.
// Reads return one function's total and change nothing.
// The back end first issues the reads of the totals RAM and the call-stack
// RAM, then adds, writes back and loads the result register. It takes a new
// request only after it has loaded the result of the previous one.
// After reset the totals RAM is cleared one entry per cycle, all 4096 entries;
// in_if.ready stays low until the sweep is done.
// When the receiver stalls, the result register holds, the back end waits,
// and the two-entry queue absorbs requests before in_if.ready drops.
module call_stack_exclusive_time_profiler (
  input  logic        clk,
  input  logic        rst_n,
  cstp_in_if.sink     in_if,
  cstp_out_if.source  out_if
);
  import cstp_pkg::*;

  logic        clearing;
  logic        push_valid, push_ready;
  logic        pop_valid, pop_ready;
  cstp_entry_t push_entry, pop_entry;

  cstp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .clearing   (clearing),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  cstp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop_ready  (pop_ready)
  );

  cstp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop_ready (pop_ready),
    .clearing  (clearing),
    .out_if    (out_if)
  );

endmodule
